[design/overwriting_ring_buffer_top_macros.svh]
// assertion helpers for the ring buffer
`ifndef OVERWRITING_RING_BUFFER_TOP_MACROS_SVH
`define OVERWRITING_RING_BUFFER_TOP_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define ORB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ORB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/orb_pkg.sv]
package orb_pkg;

   localparam int DEPTH     = 64;
   localparam int ELEM_BITS = 32;
   localparam int IDX_BITS  = $clog2(DEPTH);
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   localparam logic [CNT_BITS-1:0] CAP_MIN = CNT_BITS'(2);
   localparam logic [CNT_BITS-1:0] CAP_MAX = CNT_BITS'(DEPTH);

   localparam logic [1:0] REQ_PUT       = 2'd0;
   localparam logic [1:0] REQ_GET       = 2'd1;
   localparam logic [1:0] REQ_PEEK_OLD  = 2'd2;
   localparam logic [1:0] REQ_PEEK_BACK = 2'd3;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_EMPTY  = 2'd1;
   localparam logic [1:0] STATUS_OFFSET = 2'd2;

   typedef struct packed {
      logic [1:0]           req_type;
      logic [31:0]          write_data;
      logic [IDX_BITS-1:0]  back_offset;
   } orb_req_type;

   typedef struct packed {
      logic [31:0]          read_data;
      logic [CNT_BITS-1:0]  fill_count;
      logic                 is_empty;
      logic                 is_full;
      logic [1:0]           status;
   } orb_rsp_type;

   // next slot with wrap at the configured capacity
   function automatic logic [IDX_BITS-1:0] orb_advance(input logic [IDX_BITS-1:0] idx,
                                                       input logic [CNT_BITS-1:0] cap);
      logic [CNT_BITS-1:0] nxt;
      nxt = CNT_BITS'(idx) + CNT_BITS'(1);
      if (nxt >= cap) begin
         return '0;
      end
      return nxt[IDX_BITS-1:0];
   endfunction

   function automatic logic [CNT_BITS-1:0] orb_fill(input logic [IDX_BITS-1:0] head,
                                                    input logic [IDX_BITS-1:0] tail,
                                                    input logic                full,
                                                    input logic [CNT_BITS-1:0] cap);
      if (full) begin
         return cap;
      end
      if (head >= tail) begin
         return CNT_BITS'(head) - CNT_BITS'(tail);
      end
      return cap - CNT_BITS'(tail) + CNT_BITS'(head);
   endfunction

endpackage

[design/overwriting_ring_buffer_top.sv]
// Overwriting ring buffer of 32-bit elements, up to 64 slots, capacity set through the
// csr write channel (values clamp to 2..64; a write empties the buffer). A request is
// taken on every clock with start high (busy stays low), so one request per cycle is
// sustained. Each request gives exactly one result, strobed on rsp_strobe for a single
// cycle in the cycle right after the request is taken; the result and the read port of
// the slot memory are registered. The receiver cannot stall and must take every
// result when it is strobed. A put into a full buffer drops the oldest element. Reads of
// an empty buffer or an offset not below the count return an error status, zero data and
// leave the buffer unchanged.
`include "overwriting_ring_buffer_top_macros.svh"

module overwriting_ring_buffer_top import orb_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  orb_req_type         req_payload,
   output logic                rsp_strobe,
   output orb_rsp_type         rsp_payload,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CNT_BITS-1:0] csr_wdata
);

   logic [ELEM_BITS-1:0] slots [DEPTH];
   logic [ELEM_BITS-1:0] rd_data_ff;

   logic [IDX_BITS-1:0]  head_ff, head_in;
   logic [IDX_BITS-1:0]  tail_ff, tail_in;
   logic                 full_ff, full_in;
   logic [CNT_BITS-1:0]  cap_ff, cap_in;

   logic                 strobe_ff, strobe_in;
   logic                 rd_use_ff, rd_use_in;
   logic [CNT_BITS-1:0]  fill_ff, fill_in;
   logic                 full_out_ff;
   logic [1:0]           status_ff, status_in;

   logic                 accept;
   logic                 csr_write;
   logic                 mem_we;
   logic [IDX_BITS-1:0]  rd_addr;
   logic [CNT_BITS-1:0]  count;
   logic [CNT_BITS:0]    back_sum;
   logic [CNT_BITS:0]    back_idx;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign csr_write = csr_valid && csr_ready;

   assign count = orb_fill(head_ff, tail_ff, full_ff, cap_ff);

   // newest minus offset, wrapped once into the slots in use
   assign back_sum = (CNT_BITS+1)'(head_ff) + (CNT_BITS+1)'(cap_ff) - (CNT_BITS+1)'(1)
                     - (CNT_BITS+1)'(req_payload.back_offset);
   assign back_idx = (back_sum >= (CNT_BITS+1)'(cap_ff)) ?
                     back_sum - (CNT_BITS+1)'(cap_ff) : back_sum;

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      full_in   = full_ff;
      cap_in    = cap_ff;
      rd_use_in = 1'b0;
      status_in = STATUS_OK;
      mem_we    = 1'b0;
      rd_addr   = tail_ff;
      strobe_in = accept;

      if (csr_write) begin
         priority if (csr_wdata < CAP_MIN) begin
            cap_in = CAP_MIN;
         end else if (csr_wdata > CAP_MAX) begin
            cap_in = CAP_MAX;
         end else begin
            cap_in = csr_wdata;
         end
         head_in = '0;
         tail_in = '0;
         full_in = 1'b0;
      end else if (accept) begin
         unique case (req_payload.req_type)
            REQ_PUT: begin
               mem_we  = 1'b1;
               if (full_ff) begin
                  tail_in = orb_advance(tail_ff, cap_ff);
               end
               head_in = orb_advance(head_ff, cap_ff);
               full_in = (head_in == tail_in);
            end
            REQ_GET, REQ_PEEK_OLD: begin
               if (count == '0) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  rd_use_in = 1'b1;
                  if (req_payload.req_type == REQ_GET) begin
                     tail_in = orb_advance(tail_ff, cap_ff);
                     full_in = 1'b0;
                  end
               end
            end
            REQ_PEEK_BACK: begin
               rd_addr = back_idx[IDX_BITS-1:0];
               if (CNT_BITS'(req_payload.back_offset) >= count) begin
                  status_in = STATUS_OFFSET;
               end else begin
                  rd_use_in = 1'b1;
               end
            end
            default: begin
               status_in = STATUS_OK;
            end
         endcase
      end
      fill_in = orb_fill(head_in, tail_in, full_in, cap_in);
   end

   // slot memory: one write port at head, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slots[head_ff] <= req_payload.write_data;
      end
      rd_data_ff <= slots[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         tail_ff   <= '0;
         full_ff   <= 1'b0;
         cap_ff    <= CAP_MAX;
         strobe_ff <= 1'b0;
      end else begin
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         full_ff   <= full_in;
         cap_ff    <= cap_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_use_ff   <= rd_use_in;
      fill_ff     <= fill_in;
      full_out_ff <= full_in;
      status_ff   <= status_in;
   end

   assign rsp_strobe             = strobe_ff;
   assign rsp_payload.read_data  = rd_use_ff ? rd_data_ff : '0;
   assign rsp_payload.fill_count = fill_ff;
   assign rsp_payload.is_empty   = (fill_ff == '0);
   assign rsp_payload.is_full    = full_out_ff;
   assign rsp_payload.status     = status_ff;

   `ORB_ASSERT_NOW(a_idx_in_range, 1'b1, head_ff < cap_ff && tail_ff < cap_ff, "index past capacity")
   `ORB_ASSERT_NOW(a_full_meets, full_ff, head_ff == tail_ff, "full flag with head and tail apart")
   `ORB_ASSERT_NEXT(a_one_result, accept, rsp_strobe, "accepted request gave no result")
   `ORB_ASSERT_NOW(a_err_zero, rsp_strobe && status_ff != STATUS_OK, rsp_payload.read_data == '0, "error result carries data")
   `ORB_ASSERT_NEXT(a_put_count, accept && req_payload.req_type == REQ_PUT && !csr_write, fill_ff != '0, "put left buffer empty")

endmodule

[sim/overwriting_ring_buffer_top_test.sv]
module overwriting_ring_buffer_top_test import orb_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      bit                  is_csr;
      logic [CNT_BITS-1:0] csr_value;
      orb_req_type         req;
      bit                  has_lit;
      orb_rsp_type         lit;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   orb_req_type         req_payload = '0;
   logic                rsp_strobe;
   orb_rsp_type         rsp_payload;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CNT_BITS-1:0] csr_wdata = '0;

   // shadow copy of the buffer
   logic [ELEM_BITS-1:0] ring_slots [DEPTH];
   logic [IDX_BITS-1:0]  ring_head;
   logic [IDX_BITS-1:0]  ring_tail;
   logic                 ring_full;
   logic [CNT_BITS-1:0]  ring_cap;

   orb_rsp_type rsp_due [$];
   int          mismatches = 0;

   // literal expectation for the request being driven, if any
   bit          lit_valid = 1'b0;
   orb_rsp_type lit_rsp = '0;

   stim_row_type directed_rows [$];

   overwriting_ring_buffer_top dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [CNT_BITS-1:0] ring_held();
      if (ring_full) begin
         return ring_cap;
      end
      if (ring_head >= ring_tail) begin
         return CNT_BITS'(ring_head) - CNT_BITS'(ring_tail);
      end
      return ring_cap - CNT_BITS'(ring_tail) + CNT_BITS'(ring_head);
   endfunction

   function automatic logic [IDX_BITS-1:0] ring_next(input logic [IDX_BITS-1:0] i);
      logic [CNT_BITS-1:0] n;
      n = CNT_BITS'(i) + CNT_BITS'(1);
      return (n >= ring_cap) ? '0 : n[IDX_BITS-1:0];
   endfunction

   function automatic void ring_set_capacity(input logic [CNT_BITS-1:0] v);
      if (v < CAP_MIN) begin
         v = CAP_MIN;
      end
      if (v > CAP_MAX) begin
         v = CAP_MAX;
      end
      ring_cap  = v;
      ring_head = '0;
      ring_tail = '0;
      ring_full = 1'b0;
   endfunction

   // applies one request to the shadow buffer and gives its result
   function automatic orb_rsp_type ring_result(input orb_req_type rq);
      orb_rsp_type         res;
      logic [CNT_BITS-1:0] count;
      logic [CNT_BITS:0]   idx;
      res   = '0;
      count = ring_held();
      res.status = STATUS_OK;
      case (rq.req_type)
         REQ_PUT: begin
            if (ring_full) begin
               ring_tail = ring_next(ring_tail);
               ring_full = 1'b0;
            end
            ring_slots[ring_head] = rq.write_data;
            ring_head = ring_next(ring_head);
            if (ring_head == ring_tail) begin
               ring_full = 1'b1;
            end
         end
         REQ_GET, REQ_PEEK_OLD: begin
            if (count == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               res.read_data = ring_slots[ring_tail];
               if (rq.req_type == REQ_GET) begin
                  ring_tail = ring_next(ring_tail);
                  ring_full = 1'b0;
               end
            end
         end
         default: begin
            if (CNT_BITS'(rq.back_offset) >= count) begin
               res.status = STATUS_OFFSET;
            end else begin
               idx = (CNT_BITS+1)'(ring_head) + (CNT_BITS+1)'(ring_cap) - (CNT_BITS+1)'(1)
                     - (CNT_BITS+1)'(rq.back_offset);
               if (idx >= (CNT_BITS+1)'(ring_cap)) begin
                  idx = idx - (CNT_BITS+1)'(ring_cap);
               end
               res.read_data = ring_slots[idx[IDX_BITS-1:0]];
            end
         end
      endcase
      count = ring_held();
      res.fill_count = count;
      res.is_empty   = (count == 0);
      res.is_full    = ring_full;
      return res;
   endfunction

   task automatic flag_mismatch(input string what, input orb_rsp_type got,
                                input orb_rsp_type want);
      $display("mismatch %s at %0t: got %h expected %h", what, $realtime, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      orb_rsp_type want;
      if (reset) begin
         ring_set_capacity(CAP_MAX);
         rsp_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            ring_set_capacity(csr_wdata);
         end
         if (start && !busy) begin
            want = ring_result(req_payload);
            rsp_due.push_back(lit_valid ? lit_rsp : want);
         end
         if (rsp_strobe) begin
            if (rsp_due.size() == 0) begin
               flag_mismatch("unexpected result", rsp_payload, '0);
            end else begin
               want = rsp_due.pop_front();
               if (rsp_payload.read_data !== want.read_data)
                  flag_mismatch("read_data", rsp_payload, want);
               if (rsp_payload.fill_count !== want.fill_count)
                  flag_mismatch("fill_count", rsp_payload, want);
               if (rsp_payload.is_empty !== want.is_empty)
                  flag_mismatch("is_empty", rsp_payload, want);
               if (rsp_payload.is_full !== want.is_full)
                  flag_mismatch("is_full", rsp_payload, want);
               if (rsp_payload.status !== want.status)
                  flag_mismatch("status", rsp_payload, want);
            end
         end
      end
   end

   function automatic orb_req_type make_req(input logic [1:0] kind, input logic [31:0] data,
                                            input logic [IDX_BITS-1:0] offset);
      orb_req_type rq;
      rq.req_type    = kind;
      rq.write_data  = data;
      rq.back_offset = offset;
      return rq;
   endfunction

   function automatic void add_row(input logic [1:0] kind, input logic [31:0] data,
                                   input logic [IDX_BITS-1:0] offset);
      stim_row_type row;
      row = '{default: '0};
      row.req = make_req(kind, data, offset);
      directed_rows.push_back(row);
   endfunction

   function automatic void add_lit_row(input logic [1:0] kind, input logic [31:0] data,
                                       input logic [IDX_BITS-1:0] offset,
                                       input logic [CNT_BITS-1:0] count, input logic full,
                                       input logic [1:0] status);
      stim_row_type row;
      row = '{default: '0};
      row.req            = make_req(kind, data, offset);
      row.has_lit        = 1'b1;
      row.lit.read_data  = '0;
      row.lit.fill_count = count;
      row.lit.is_empty   = (count == 0);
      row.lit.is_full    = full;
      row.lit.status     = status;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_csr_row(input logic [CNT_BITS-1:0] v);
      stim_row_type row;
      row = '{default: '0};
      row.is_csr    = 1'b1;
      row.csr_value = v;
      directed_rows.push_back(row);
   endfunction

   task automatic wait_drained();
      start = 1'b0;
      while (rsp_due.size() != 0) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CNT_BITS-1:0] v);
      wait_drained();
      csr_valid = 1'b1;
      csr_wdata = v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // start stays high after the transfer so back-to-back requests need no toggle
   task automatic send_req(input orb_req_type rq, input bit lit_on, input orb_rsp_type lit);
      req_payload = rq;
      lit_valid   = lit_on;
      lit_rsp     = lit;
      start       = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic idle_gap(input bit quiet);
      int n;
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) begin
         n = 0;
      end else if (r < 90) begin
         n = $urandom_range(1, 3);
      end else if (r < 98) begin
         n = $urandom_range(4, 15);
      end else begin
         n = $urandom_range(20, 60);
      end
      if (n > 0) begin
         start = 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   initial begin
      int                  items;
      int                  phase;
      int                  phase_len;
      int                  put_w;
      int                  r;
      int                  k;
      bit                  quiet;
      logic [1:0]          kind;
      logic [31:0]         data;
      logic [IDX_BITS-1:0] offset;
      logic [CNT_BITS-1:0] cv;

      // empty-buffer errors, clamping, overwrite of a full buffer, offset errors
      add_lit_row(REQ_GET, 32'h0, 0, 0, 1'b0, STATUS_EMPTY);
      add_lit_row(REQ_PEEK_OLD, 32'hFFFF_FFFF, 0, 0, 1'b0, STATUS_EMPTY);
      add_lit_row(REQ_PEEK_BACK, 32'h0, 0, 0, 1'b0, STATUS_OFFSET);
      add_csr_row(7'd0);
      add_lit_row(REQ_PUT, 32'hFFFF_FFFF, 6'h3F, 1, 1'b0, STATUS_OK);
      add_lit_row(REQ_PUT, 32'h0, 0, 2, 1'b1, STATUS_OK);
      add_lit_row(REQ_PUT, 32'h1234_5678, 0, 2, 1'b1, STATUS_OK);
      add_row(REQ_PEEK_OLD, 32'h0, 0);
      add_row(REQ_PEEK_BACK, 32'h0, 0);
      add_row(REQ_PEEK_BACK, 32'h0, 1);
      add_lit_row(REQ_PEEK_BACK, 32'h0, 2, 2, 1'b1, STATUS_OFFSET);
      add_lit_row(REQ_PEEK_BACK, 32'h0, 6'h3F, 2, 1'b1, STATUS_OFFSET);
      add_row(REQ_GET, 32'h0, 0);
      add_row(REQ_GET, 32'h0, 0);
      add_lit_row(REQ_GET, 32'h0, 0, 0, 1'b0, STATUS_EMPTY);
      add_csr_row(7'd127);
      add_row(REQ_PUT, 32'hA5A5_A5A5, 0);
      add_row(REQ_PUT, 32'h5A5A_5A5A, 0);
      add_row(REQ_PEEK_BACK, 32'h0, 1);
      add_lit_row(REQ_PEEK_BACK, 32'h0, 2, 2, 1'b0, STATUS_OFFSET);
      add_row(REQ_GET, 32'h0, 0);
      add_csr_row(7'd1);
      add_row(REQ_PUT, 32'h8000_0001, 0);
      add_row(REQ_PUT, 32'h7FFF_FFFE, 0);
      add_csr_row(7'd65);
      add_lit_row(REQ_PEEK_OLD, 32'h0, 0, 0, 1'b0, STATUS_EMPTY);

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            write_capacity(directed_rows[i].csr_value);
         end else begin
            send_req(directed_rows[i].req, directed_rows[i].has_lit, directed_rows[i].lit);
            idle_gap(1'b0);
         end
      end
      lit_valid = 1'b0;

      items = 0;
      phase = 0;
      while (items < 1700) begin
         case (phase % 6)
            0: cv = CAP_MIN;
            1: cv = CAP_MAX;
            2: cv = CNT_BITS'($urandom_range(2, DEPTH));
            3: cv = CNT_BITS'($urandom_range(0, 127));
            4: cv = CNT_BITS'($urandom_range(2, 8));
            default: cv = ($urandom_range(0, 1) != 0) ? CNT_BITS'($urandom_range(0, 1))
                                                      : CNT_BITS'($urandom_range(65, 127));
         endcase
         write_capacity(cv);
         phase_len = $urandom_range(60, 250);
         put_w     = $urandom_range(20, 80);
         quiet     = ($urandom_range(0, 3) == 0);
         for (k = 0; k < phase_len && items < 1700; k++) begin
            r = $urandom_range(0, 99);
            if (r < put_w) begin
               kind = REQ_PUT;
            end else begin
               case ($urandom_range(0, 3))
                  0, 1: kind = REQ_GET;
                  2: kind = REQ_PEEK_OLD;
                  default: kind = REQ_PEEK_BACK;
               endcase
            end
            case ($urandom_range(0, 15))
               0: data = 32'h0;
               1: data = 32'hFFFF_FFFF;
               default: data = $urandom;
            endcase
            if (ring_held() != 0 && $urandom_range(0, 3) != 0) begin
               offset = IDX_BITS'($urandom_range(0, ring_held() - 1));
            end else begin
               offset = IDX_BITS'($urandom_range(0, 63));
            end
            send_req(make_req(kind, data, offset), 1'b0, '0);
            items++;
            if (k == phase_len / 2) begin
               wait_drained();
            end
            idle_gap(quiet);
         end
         phase++;
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && rsp_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("FAIL");
      $finish;
   end

endmodule
